// ----- rtl/blp_pkg.sv -----
// shared constants and types of the bezier / line path point generator
// no dependencies; used by every module of the block
package blp_pkg;

    localparam int OUT_BITS       = 20;   // point_x / point_y width, 8 fraction bits
    localparam int Z_BITS         = 12;   // height width
    localparam int STEPS_BITS     = 7;    // width of the steps field
    localparam int FRAC_SHIFT     = 9;    // num * 512: 8 fraction bits plus one for the half
    localparam int DEF_MAX_STEPS  = 64;
    localparam int DEF_COORD_BITS = 12;

    // segment kinds
    localparam logic CMD_BEZIER = 1'b0;
    localparam logic CMD_LINE   = 1'b1;

    // per-cycle control from the sequencer to both coordinate lanes
    typedef struct packed {
        logic clr;      // clear the accumulator
        logic mac;      // add one weight bit column
        logic dload;    // form dividend and load the divider
        logic dstep;    // one restoring division step
    } t_lane_ctl;

    // current msb of each serial weight
    typedef struct packed {
        logic w0;
        logic w1;
        logic w2;
    } t_wbits;

endpackage

// ----- rtl/blp_wgen.sv -----
// blend weight generator: computes the three weights and the divisor of one point
// and shifts the weights out msb first; depends on blp_pkg
module blp_wgen #(
    parameter  int MAX_STEPS = blp_pkg::DEF_MAX_STEPS,
    localparam int SB        = $clog2(MAX_STEPS + 1),
    localparam int IB        = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1,
    localparam int WB        = 2 * SB
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_shift,
    input  logic             i_cmd,
    input  logic [SB-1:0]    i_n,
    input  logic [IB-1:0]    i_idx,
    output blp_pkg::t_wbits  o_bits,
    output logic [WB-1:0]    o_den
);
    import blp_pkg::*;

    logic [WB-1:0] r_w0, r_w1, r_w2, r_den;
    logic [WB-1:0] n_w0, n_w1, n_w2, n_den;
    logic [WB-1:0] ne, ie, re;

    assign ne = WB'(i_n);
    assign ie = WB'(i_idx);
    assign re = ne - ie;

    always_comb begin
        if (i_cmd == CMD_LINE) begin
            n_w0  = re;
            n_w1  = '0;
            n_w2  = ie;
            n_den = ne;
        end else begin
            n_w0  = re * re;
            n_w1  = (ie * re) << 1;
            n_w2  = ie * ie;
            n_den = ne * ne;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_w0  <= n_w0;
            r_w1  <= n_w1;
            r_w2  <= n_w2;
            r_den <= n_den;
        end else if (i_shift) begin
            r_w0 <= r_w0 << 1;
            r_w1 <= r_w1 << 1;
            r_w2 <= r_w2 << 1;
        end
    end

    assign o_bits.w0 = r_w0[WB-1];
    assign o_bits.w1 = r_w1[WB-1];
    assign o_bits.w2 = r_w2[WB-1];
    assign o_den     = r_den;

endmodule

// ----- rtl/blp_lane.sv -----
// one coordinate lane: bit-serial weighted sum, serial restoring divider,
// rounding sign fix-up and saturation; depends on blp_pkg
module blp_lane #(
    parameter  int COORD_BITS = blp_pkg::DEF_COORD_BITS,
    parameter  int WB         = 14,
    localparam int QB         = COORD_BITS + 9
) (
    input  logic                          i_clk,
    input  blp_pkg::t_lane_ctl            i_ctl,
    input  blp_pkg::t_wbits               i_bits,
    input  logic signed [COORD_BITS-1:0]  i_p0,
    input  logic signed [COORD_BITS-1:0]  i_p1,
    input  logic signed [COORD_BITS-1:0]  i_p2,
    input  logic [WB-1:0]                 i_den,
    output logic [blp_pkg::OUT_BITS-1:0]  o_coord
);
    import blp_pkg::*;

    localparam int AW = COORD_BITS + WB + 2;
    localparam int NW = AW + FRAC_SHIFT + 1;
    localparam int DW = WB + 2;
    localparam int SW = (QB + 2 > OUT_BITS) ? QB + 2 : OUT_BITS;
    localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (OUT_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic signed [AW-1:0] r_acc, n_acc, term;
    logic [DW-1:0]        r_rem, n_rem, rem2, dval;
    logic [QB-1:0]        r_low, n_low, r_quo, n_quo;
    logic                 r_neg, n_neg, ge;
    logic signed [NW-1:0] dividend;
    logic [NW-1:0]        mag;
    logic signed [SW-1:0] qmag, qs;

    // column of the three weight bits times the points
    always_comb begin
        term = '0;
        if (i_bits.w0) term = term + AW'(i_p0);
        if (i_bits.w1) term = term + AW'(i_p1);
        if (i_bits.w2) term = term + AW'(i_p2);
    end

    // num * 512 + den, split into sign and magnitude
    assign dividend = (NW'(r_acc) <<< FRAC_SHIFT) + $signed(NW'(i_den));
    assign mag      = dividend[NW-1] ? $unsigned(-dividend) : $unsigned(dividend);

    assign dval = DW'({i_den, 1'b0});
    assign rem2 = {r_rem[DW-2:0], r_low[QB-1]};
    assign ge   = (rem2 >= dval);

    always_comb begin
        n_acc = r_acc;
        n_rem = r_rem;
        n_low = r_low;
        n_quo = r_quo;
        n_neg = r_neg;
        if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.mac) begin
            n_acc = (r_acc <<< 1) + term;
        end
        if (i_ctl.dload) begin
            n_rem = mag[QB+DW-1:QB];
            n_low = mag[QB-1:0];
            n_quo = '0;
            n_neg = dividend[NW-1];
        end else if (i_ctl.dstep) begin
            n_rem = ge ? rem2 - dval : rem2;
            n_low = r_low << 1;
            n_quo = {r_quo[QB-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_low <= n_low;
        r_quo <= n_quo;
        r_neg <= n_neg;
    end

    // floor for negative dividends: bump the magnitude on a nonzero remainder
    assign qmag = $signed(SW'(r_quo)) + $signed(SW'(r_neg && (r_rem != '0)));
    assign qs   = r_neg ? -qmag : qmag;

    always_comb begin
        if (qs > SAT_HI) begin
            o_coord = SAT_HI[OUT_BITS-1:0];
        end else if (qs < SAT_LO) begin
            o_coord = SAT_LO[OUT_BITS-1:0];
        end else begin
            o_coord = qs[OUT_BITS-1:0];
        end
    end

endmodule

// ----- rtl/bezier_line_path_generator_core.sv -----
// top level of the bezier / line path point generator: sequencer, segment
// registers and output register; depends on blp_pkg, blp_wgen, blp_lane
//
// channel  direction  handshake                 payload
// segment  in         i_in_valid / o_in_ready   i_command, i_start_*, i_ctrl_*, i_end_*,
//                                               i_steps, i_height
// point    out        o_out_valid / i_out_ready o_point_x, o_point_y, o_point_z, o_last
//
// each point is worked on in these steps, in order:
// weight setup, WB bit-serial multiply-accumulate columns (WB = 2*ceil(log2(MAX_STEPS+1))),
// divider load, QB = COORD_BITS + 9 restoring division steps, then the output write
// the divider is serial, so one segment is worked on at a time; a segment with
// zero steps is taken and produces nothing
// reset is synchronous and active low, and clears the sequencer and output valid
// a stalled output holds the finished point in the output register and the
// sequencer waits in its write state until that register frees up
module bezier_line_path_generator_core #(
    parameter int MAX_STEPS  = blp_pkg::DEF_MAX_STEPS,
    parameter int COORD_BITS = blp_pkg::DEF_COORD_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_command,
    input  logic signed [COORD_BITS-1:0]          i_start_x,
    input  logic signed [COORD_BITS-1:0]          i_start_y,
    input  logic signed [COORD_BITS-1:0]          i_ctrl_x,
    input  logic signed [COORD_BITS-1:0]          i_ctrl_y,
    input  logic signed [COORD_BITS-1:0]          i_end_x,
    input  logic signed [COORD_BITS-1:0]          i_end_y,
    input  logic [blp_pkg::STEPS_BITS-1:0]        i_steps,
    input  logic signed [blp_pkg::Z_BITS-1:0]     i_height,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [blp_pkg::OUT_BITS-1:0]   o_point_x,
    output logic signed [blp_pkg::OUT_BITS-1:0]   o_point_y,
    output logic signed [blp_pkg::Z_BITS-1:0]     o_point_z,
    output logic                                  o_last
);
    import blp_pkg::*;

    localparam int SB = $clog2(MAX_STEPS + 1);            // bits of a step count
    localparam int IB = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1; // bits of a point index
    localparam int WB = 2 * SB;                            // serial weight length
    localparam int QB = COORD_BITS + 9;                    // quotient bits
    localparam int CW = $clog2(((QB > WB) ? QB : WB) + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WGT,
        S_MAC,
        S_DLD,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;

    // segment registers
    logic                          r_cmd;
    logic signed [COORD_BITS-1:0]  r_p0x, r_p0y, r_p1x, r_p1y, r_p2x, r_p2y;
    logic [SB-1:0]                 r_n;
    logic signed [Z_BITS-1:0]      r_z;
    logic [IB-1:0]                 r_idx;     // point being worked on
    logic [CW-1:0]                 r_cnt;     // serial step counter

    // output register
    logic                          r_out_valid;
    logic [OUT_BITS-1:0]           r_px, r_py;
    logic signed [Z_BITS-1:0]      r_pz;
    logic                          r_last;

    logic [SB-1:0]                 steps_sat;
    logic                          in_acc;
    logic                          out_free;
    logic                          idx_last;
    t_lane_ctl                     lane_ctl;
    t_wbits                        wbits;
    logic [WB-1:0]                 den;
    logic [OUT_BITS-1:0]           coord_x, coord_y;

    // steps above the maximum clamp to it
    assign steps_sat = (i_steps > STEPS_BITS'(MAX_STEPS)) ? SB'(MAX_STEPS) : i_steps[SB-1:0];

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign idx_last   = ((SB'(r_idx) + SB'(1)) == r_n);

    assign lane_ctl.clr   = (r_state == S_WGT);
    assign lane_ctl.mac   = (r_state == S_MAC);
    assign lane_ctl.dload = (r_state == S_DLD);
    assign lane_ctl.dstep = (r_state == S_DIV);

    blp_wgen #(
        .MAX_STEPS (MAX_STEPS)
    ) u_wgen (
        .i_clk   (i_clk),
        .i_load  (r_state == S_WGT),
        .i_shift (r_state == S_MAC),
        .i_cmd   (r_cmd),
        .i_n     (r_n),
        .i_idx   (r_idx),
        .o_bits  (wbits),
        .o_den   (den)
    );

    blp_lane #(
        .COORD_BITS (COORD_BITS),
        .WB         (WB)
    ) u_lane_x (
        .i_clk   (i_clk),
        .i_ctl   (lane_ctl),
        .i_bits  (wbits),
        .i_p0    (r_p0x),
        .i_p1    (r_p1x),
        .i_p2    (r_p2x),
        .i_den   (den),
        .o_coord (coord_x)
    );

    blp_lane #(
        .COORD_BITS (COORD_BITS),
        .WB         (WB)
    ) u_lane_y (
        .i_clk   (i_clk),
        .i_ctl   (lane_ctl),
        .i_bits  (wbits),
        .i_p0    (r_p0y),
        .i_p1    (r_p1y),
        .i_p2    (r_p2y),
        .i_den   (den),
        .o_coord (coord_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a write from the sequencer refills the register, otherwise it drains
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd <= i_command;
                        r_p0x <= i_start_x;
                        r_p0y <= i_start_y;
                        r_p1x <= i_ctrl_x;
                        r_p1y <= i_ctrl_y;
                        r_p2x <= i_end_x;
                        r_p2y <= i_end_y;
                        r_n   <= steps_sat;
                        r_z   <= i_height;
                        r_idx <= '0;
                        // empty segment: nothing to emit
                        if (steps_sat != '0) begin
                            r_state <= S_WGT;
                        end
                    end
                end
                S_WGT: begin
                    r_cnt   <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (r_cnt == CW'(WB - 1)) begin
                        r_state <= S_DLD;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_DLD: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == CW'(QB - 1)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_px        <= coord_x;
                        r_py        <= coord_y;
                        r_pz        <= r_z;
                        r_last      <= idx_last;
                        if (idx_last) begin
                            r_idx   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + IB'(1);
                            r_state <= S_WGT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_px;
    assign o_point_y   = r_py;
    assign o_point_z   = r_pz;
    assign o_last      = r_last;

`ifndef SYNTH
    // the point index never reaches the segment's point count while busy
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (SB'(r_idx) < r_n))
        else $error("point index out of range");

    // a segment with points keeps the input side closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (steps_sat != '0)) |=> !o_in_ready)
        else $error("input taken again while a segment is in work");

    // when the sequencer leaves the write state, the output register holds a valid point
    a_write_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_state) == S_EMIT && r_state != S_EMIT) |-> r_out_valid)
        else $error("point lost on output write");

    // reset leaves no point pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule
